FILE: src/ffbt_pkg.sv
// Shared request codes, field widths and the completion record
// passed from the sequencer to the response stage. No dependencies.
package ffbt_pkg;

   localparam int REQ_SIZE_W = 11;
   localparam int REQ_ADDR_W = 10;
   localparam int BLK_ADDR_W = 10;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic                  ok;
      logic [BLK_ADDR_W-1:0] addr;
   } done_type;

endpackage

FILE: src/ffbt_req_if.sv
// Request channel: valid/ready plus the allocate/free payload.
// Depends on ffbt_pkg for field widths.
interface ffbt_req_if import ffbt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [REQ_SIZE_W-1:0] req_size;
   logic [REQ_ADDR_W-1:0] req_addr;

   modport source (output valid, req_type, req_size, req_addr, input ready);
   modport sink   (input valid, req_type, req_size, req_addr, output ready);
endinterface

FILE: src/ffbt_rsp_if.sv
// Response channel: valid/ready plus success flag and block offset.
// Depends on ffbt_pkg for field widths.
interface ffbt_rsp_if import ffbt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [BLK_ADDR_W-1:0] block_addr;

   modport source (output valid, ok, block_addr, input ready);
   modport sink   (input valid, ok, block_addr, output ready);
endinterface

FILE: src/ffbt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffbt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ffbt_ctrl.sv
// Header sequencer: clearing pass, first-fit walk, split and coalesce.
// Depends on ffbt_pkg, ffbt_req_if and ffbt_ram.
module ffbt_ctrl import ffbt_pkg::*; #(
   parameter int ARENA_WORDS = 1024,
   parameter int HDR_WORDS   = 3
) (
   input  logic          clock,
   input  logic          reset,
   ffbt_req_if.sink      req_ch,
   output done_type      done,
   input  logic          done_ready
);

   localparam int AW = $clog2(ARENA_WORDS);
   localparam int SW = $clog2(ARENA_WORDS + 1);
   localparam int CW = ((SW > REQ_SIZE_W) ? SW : REQ_SIZE_W) + 2;
   localparam logic [CW-1:0] ARENA_C = CW'(ARENA_WORDS);
   localparam logic [CW-1:0] HDR_C   = CW'(HDR_WORDS);

   typedef struct packed {
      logic          start;
      logic          used;
      logic [SW-1:0] prev;
      logic [SW-1:0] size;
   } word_type;

   localparam int MW = $bits(word_type);

   typedef enum logic [3:0] {
      CLEAR, IDLE, A_CHK, F_CUR, F_PREV, F_NEXT, W1, Z1, Z2, RDF, FIX, DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         h_ff, h_in;
   logic [AW-1:0]         p_ff, p_in;
   logic [AW-1:0]         n_ff, n_in;
   logic [REQ_SIZE_W-1:0] size_ff, size_in;
   logic [SW-1:0]         csz_ff, csz_in, cprev_ff, cprev_in;
   logic [SW-1:0]         psz_ff, psz_in, pprev_ff, pprev_in;
   logic [SW-1:0]         tot_ff, tot_in;
   logic                  cand_ff, cand_in, hprev_ff, hprev_in, pfree_ff, pfree_in;
   logic                  hnext_ff, hnext_in;
   logic [AW-1:0]         w1_addr_ff, w1_addr_in;
   word_type              w1_data_ff, w1_data_in;
   logic                  z1_ff, z1_in, z2_ff, z2_in, fix_ff, fix_in;
   logic [AW-1:0]         fix_addr_ff, fix_addr_in;
   logic                  ok_ff, ok_in;
   logic [BLK_ADDR_W-1:0] addr_ff, addr_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   word_type              wr_word, rd_word;
   logic [MW-1:0]         rd_raw;

   logic [CW-1:0]         sz_c, req_c, nx_c, diff_c, hw_c, back_c, pay_c, n2_c, nxc_c;
   logic                  pm, nm;

   ffbt_ram #(.WIDTH(MW), .DEPTH(ARENA_WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_word = word_type'(rd_raw);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      h_in        = h_ff;
      p_in        = p_ff;
      n_in        = n_ff;
      size_in     = size_ff;
      csz_in      = csz_ff;
      cprev_in    = cprev_ff;
      psz_in      = psz_ff;
      pprev_in    = pprev_ff;
      tot_in      = tot_ff;
      cand_in     = cand_ff;
      hprev_in    = hprev_ff;
      pfree_in    = pfree_ff;
      hnext_in    = hnext_ff;
      w1_addr_in  = w1_addr_ff;
      w1_data_in  = w1_data_ff;
      z1_in       = z1_ff;
      z2_in       = z2_ff;
      fix_in      = fix_ff;
      fix_addr_in = fix_addr_ff;
      ok_in       = ok_ff;
      addr_in     = addr_ff;
      wr_en       = 1'b0;
      wr_addr     = h_ff;
      wr_word     = '0;
      rd_en       = 1'b0;
      rd_addr     = h_ff;

      sz_c   = CW'(rd_word.size);
      req_c  = CW'(size_ff);
      nx_c   = CW'(h_ff) + HDR_C + sz_c;
      diff_c = sz_c - req_c;
      pay_c  = CW'(h_ff) + HDR_C;
      hw_c   = CW'(req_ch.req_addr) - HDR_C;
      back_c = HDR_C + CW'(rd_word.prev);
      nxc_c  = CW'(h_ff) + HDR_C + CW'(csz_ff);
      n2_c   = CW'(n_ff) + HDR_C + sz_c;
      pm     = hprev_ff && pfree_ff;
      nm     = hnext_ff && !rd_word.used;

      unique case (state_ff)
         CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            if (cnt_ff == '0) begin
               wr_word = '{start: 1'b1, used: 1'b0, prev: '0,
                           size: SW'(ARENA_WORDS - HDR_WORDS)};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(ARENA_WORDS - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_ch.valid) begin
               z1_in  = 1'b0;
               z2_in  = 1'b0;
               fix_in = 1'b0;
               ok_in  = 1'b0;
               addr_in = '0;
               if (req_ch.req_type == REQ_ALLOC) begin
                  size_in  = req_ch.req_size;
                  h_in     = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = A_CHK;
               end else if (CW'(req_ch.req_addr) < HDR_C || hw_c >= ARENA_C) begin
                  state_in = DONE;
               end else begin
                  h_in     = hw_c[AW-1:0];
                  rd_en    = 1'b1;
                  rd_addr  = hw_c[AW-1:0];
                  state_in = F_CUR;
               end
            end
         end
         A_CHK: begin
            if (!rd_word.used && sz_c >= req_c) begin
               ok_in   = 1'b1;
               addr_in = pay_c[BLK_ADDR_W-1:0];
               wr_en   = 1'b1;
               wr_addr = h_ff;
               if (diff_c < HDR_C) begin
                  wr_word  = '{start: 1'b1, used: 1'b1, prev: rd_word.prev,
                               size: rd_word.size};
                  state_in = DONE;
               end else begin
                  // split off the free tail, then fix the successor's back-size
                  wr_word    = '{start: 1'b1, used: 1'b1, prev: rd_word.prev,
                                 size: SW'(size_ff)};
                  tot_in     = SW'(diff_c - HDR_C);
                  w1_addr_in = AW'(pay_c + req_c);
                  w1_data_in = '{start: 1'b1, used: 1'b0, prev: SW'(size_ff),
                                 size: SW'(diff_c - HDR_C)};
                  fix_in      = nx_c < ARENA_C;
                  fix_addr_in = nx_c[AW-1:0];
                  state_in    = W1;
               end
            end else if (nx_c >= ARENA_C) begin
               state_in = DONE;
            end else begin
               h_in    = nx_c[AW-1:0];
               rd_en   = 1'b1;
               rd_addr = nx_c[AW-1:0];
            end
         end
         F_CUR: begin
            if (!rd_word.start || !rd_word.used) begin
               state_in = DONE;
            end else begin
               csz_in   = rd_word.size;
               cprev_in = rd_word.prev;
               cand_in  = (h_ff != '0) && (back_c <= CW'(h_ff));
               p_in     = AW'(CW'(h_ff) - back_c);
               rd_en    = 1'b1;
               rd_addr  = AW'(CW'(h_ff) - back_c);
               state_in = F_PREV;
            end
         end
         F_PREV: begin
            hprev_in = cand_ff && rd_word.start;
            pfree_in = !rd_word.used;
            psz_in   = rd_word.size;
            pprev_in = rd_word.prev;
            hnext_in = nxc_c < ARENA_C;
            n_in     = nxc_c[AW-1:0];
            rd_en    = 1'b1;
            rd_addr  = nxc_c[AW-1:0];
            state_in = F_NEXT;
         end
         F_NEXT: begin
            ok_in    = 1'b1;
            state_in = W1;
            priority if (pm && nm) begin
               tot_in      = SW'(CW'(psz_ff) + CW'(csz_ff) + sz_c + HDR_C + HDR_C);
               w1_addr_in  = p_ff;
               w1_data_in  = '{start: 1'b1, used: 1'b0, prev: pprev_ff,
                               size: SW'(CW'(psz_ff) + CW'(csz_ff) + sz_c + HDR_C + HDR_C)};
               z1_in       = 1'b1;
               z2_in       = 1'b1;
               fix_in      = n2_c < ARENA_C;
               fix_addr_in = n2_c[AW-1:0];
            end else if (pm) begin
               tot_in      = SW'(CW'(psz_ff) + CW'(csz_ff) + HDR_C);
               w1_addr_in  = p_ff;
               w1_data_in  = '{start: 1'b1, used: 1'b0, prev: pprev_ff,
                               size: SW'(CW'(psz_ff) + CW'(csz_ff) + HDR_C)};
               z1_in       = 1'b1;
               fix_in      = hnext_ff;
               fix_addr_in = n_ff;
            end else if (nm) begin
               tot_in      = SW'(CW'(csz_ff) + sz_c + HDR_C);
               w1_addr_in  = h_ff;
               w1_data_in  = '{start: 1'b1, used: 1'b0, prev: cprev_ff,
                               size: SW'(CW'(csz_ff) + sz_c + HDR_C)};
               z2_in       = 1'b1;
               fix_in      = n2_c < ARENA_C;
               fix_addr_in = n2_c[AW-1:0];
            end else begin
               w1_addr_in  = h_ff;
               w1_data_in  = '{start: 1'b1, used: 1'b0, prev: cprev_ff, size: csz_ff};
            end
         end
         W1: begin
            wr_en   = 1'b1;
            wr_addr = w1_addr_ff;
            wr_word = w1_data_ff;
            priority if (z1_ff)  state_in = Z1;
            else if (z2_ff)      state_in = Z2;
            else if (fix_ff)     state_in = RDF;
            else                 state_in = DONE;
         end
         Z1: begin
            wr_en   = 1'b1;
            wr_addr = h_ff;
            priority if (z2_ff)  state_in = Z2;
            else if (fix_ff)     state_in = RDF;
            else                 state_in = DONE;
         end
         Z2: begin
            wr_en    = 1'b1;
            wr_addr  = n_ff;
            state_in = fix_ff ? RDF : DONE;
         end
         RDF: begin
            rd_en    = 1'b1;
            rd_addr  = fix_addr_ff;
            state_in = FIX;
         end
         FIX: begin
            wr_en    = 1'b1;
            wr_addr  = fix_addr_ff;
            wr_word  = '{start: rd_word.start, used: rd_word.used, prev: tot_ff,
                         size: rd_word.size};
            state_in = DONE;
         end
         DONE: begin
            if (done_ready) begin
               state_in = IDLE;
            end
         end
         default: state_in = CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      h_ff        <= h_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      size_ff     <= size_in;
      csz_ff      <= csz_in;
      cprev_ff    <= cprev_in;
      psz_ff      <= psz_in;
      pprev_ff    <= pprev_in;
      tot_ff      <= tot_in;
      cand_ff     <= cand_in;
      hprev_ff    <= hprev_in;
      pfree_ff    <= pfree_in;
      hnext_ff    <= hnext_in;
      w1_addr_ff  <= w1_addr_in;
      w1_data_ff  <= w1_data_in;
      z1_ff       <= z1_in;
      z2_ff       <= z2_in;
      fix_ff      <= fix_in;
      fix_addr_ff <= fix_addr_in;
      ok_ff       <= ok_in;
      addr_ff     <= addr_in;
   end

   assign req_ch.ready = (state_ff == IDLE);
   assign done.valid   = (state_ff == DONE);
   assign done.ok      = ok_ff;
   assign done.addr    = addr_ff;

endmodule

FILE: src/first_fit_boundary_tag_allocator.sv
// First-fit boundary-tag allocator over an arena of ARENA_WORDS words.
// A request beat on req_ch carries req_type (allocate or free), req_size
// (payload words for an allocate) and req_addr (payload offset to free).
// Every request gives exactly one response beat on rsp_ch: ok, and for a
// successful allocate the payload offset in block_addr (zero otherwise).
// Block headers live in one single-port-read RAM of ARENA_WORDS entries;
// each header read is registered, so an allocate reads one header per
// block walked until the first fit, then writes that header and, when the
// block is split, also the free tail and the successor's back-size. A free
// reads the block and both neighbours, then writes the freed or merged header.
// Requests are taken one at a time. After a synchronous reset the header
// RAM is swept over all ARENA_WORDS entries while req_ch.ready stays low.
// The response sits in an output register; while rsp_ch is stalled the
// sequencer finishes the next request up to its result and holds there.
module first_fit_boundary_tag_allocator import ffbt_pkg::*; #(
   parameter int ARENA_WORDS = 1024,
   parameter int HDR_WORDS   = 3
) (
   input  logic       clock,
   input  logic       reset,
   ffbt_req_if.sink   req_ch,
   ffbt_rsp_if.source rsp_ch
);

   done_type              done;
   logic                  done_ready;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [BLK_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   ffbt_ctrl #(.ARENA_WORDS(ARENA_WORDS), .HDR_WORDS(HDR_WORDS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .done       (done),
      .done_ready (done_ready)
   );

   assign done_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      // load a finished result once the slot is free
      if (done.valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = done.ok;
         rsp_addr_in  = done.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ok         = rsp_ok_ff;
   assign rsp_ch.block_addr = rsp_addr_ff;

   a_sweep_after_reset: assert property (@(posedge clock) reset |=> !req_ch.ready)
      else $error("request taken during header sweep");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !done.valid)
      else $error("sequencer idle with a result pending");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      done.valid && !done.ok |-> done.addr == '0)
      else $error("failed request with non-zero offset");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      done.valid && done_ready |=> req_ch.ready && rsp_ch.valid)
      else $error("result handed over without returning to idle");

endmodule

FILE: verif/first_fit_boundary_tag_allocator_tb.sv
// Self-checking testbench for first_fit_boundary_tag_allocator: allocate/free
// traffic checked against an arena model held in the bench.
// Depends on ffbt_pkg, ffbt_req_if, ffbt_rsp_if and the allocator RTL.
`timescale 1ns / 100ps

module first_fit_boundary_tag_allocator_tb;
   import ffbt_pkg::*;

   localparam int ARENA = 1024;
   localparam int HDR   = 3;
   localparam int N_RANDOM = 1530;

   typedef struct packed {
      logic                  kind;
      logic [REQ_SIZE_W-1:0] size;
      logic [REQ_ADDR_W-1:0] addr;
   } arena_req_type;

   typedef struct packed {
      logic                  ok;
      logic [BLK_ADDR_W-1:0] addr;
   } arena_rsp_type;

   logic clock;
   logic reset;

   ffbt_req_if req_ch ();
   ffbt_rsp_if rsp_ch ();

   first_fit_boundary_tag_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // arena shadow: header starts, payload size, back-size, used flag
   bit          blk_start [ARENA];
   int unsigned blk_size  [ARENA];
   int unsigned blk_back  [ARENA];
   bit          blk_used  [ARENA];
   int unsigned live_blocks[$];

   arena_req_type pending_reqs[$];
   arena_rsp_type expected_rsps[$];

   int  n_accepted;
   int  n_checked;
   int  n_errors;
   int  n_alloc_ok;
   int  n_alloc_fail;
   int  n_free_ok;
   int  n_free_bad;
   bit  quiet;

   function automatic void arena_clear();
      for (int i = 0; i < ARENA; i++) begin
         blk_start[i] = 1'b0;
         blk_size[i]  = 0;
         blk_back[i]  = 0;
         blk_used[i]  = 1'b0;
      end
      blk_start[0] = 1'b1;
      blk_size[0]  = ARENA - HDR;
      live_blocks.delete();
   endfunction

   function automatic void wipe_header(input int unsigned h);
      blk_start[h] = 1'b0;
      blk_size[h]  = 0;
      blk_back[h]  = 0;
      blk_used[h]  = 1'b0;
   endfunction

   function automatic arena_rsp_type first_fit_alloc(input int unsigned want);
      arena_rsp_type r;
      int unsigned   h;
      int unsigned   nx;
      int unsigned   tail;
      int unsigned   rem;
      r = '0;
      h = 0;
      for (int steps = 0; steps < ARENA; steps++) begin
         nx = h + HDR + blk_size[h];
         if (!blk_used[h] && blk_size[h] >= want) begin
            if (blk_size[h] - want < HDR) begin
               blk_used[h] = 1'b1;
            end else begin
               tail = h + HDR + want;
               rem  = blk_size[h] - want - HDR;
               blk_size[h]     = want;
               blk_used[h]     = 1'b1;
               blk_start[tail] = 1'b1;
               blk_size[tail]  = rem;
               blk_back[tail]  = want;
               blk_used[tail]  = 1'b0;
               if (nx < ARENA) blk_back[nx] = rem;
            end
            r.ok   = 1'b1;
            r.addr = BLK_ADDR_W'(h + HDR);
            live_blocks.push_back(h + HDR);
            return r;
         end
         if (nx >= ARENA) break;
         h = nx;
      end
      return r;
   endfunction

   function automatic arena_rsp_type coalescing_free(input int unsigned a);
      arena_rsp_type r;
      int unsigned   h, p, n, n2, nx, back, tot;
      bit            prev_free, next_free, has_next;
      r = '0;
      prev_free = 1'b0;
      next_free = 1'b0;
      has_next  = 1'b0;
      p = 0;
      n = 0;
      if (a < HDR) return r;
      h = a - HDR;
      if (h >= ARENA || !blk_start[h] || !blk_used[h]) return r;
      if (h != 0) begin
         back = HDR + blk_back[h];
         if (back <= h && blk_start[h - back]) begin
            p = h - back;
            prev_free = !blk_used[p];
         end
      end
      nx = h + HDR + blk_size[h];
      if (nx < ARENA) begin
         has_next  = 1'b1;
         n         = nx;
         next_free = !blk_used[n];
      end
      if (prev_free && next_free) begin
         tot = blk_size[p] + blk_size[h] + blk_size[n] + 2 * HDR;
         n2  = n + HDR + blk_size[n];
         blk_size[p] = tot;
         wipe_header(h);
         wipe_header(n);
         if (n2 < ARENA) blk_back[n2] = tot;
      end else if (prev_free) begin
         tot = blk_size[p] + blk_size[h] + HDR;
         blk_size[p] = tot;
         wipe_header(h);
         if (has_next) blk_back[n] = tot;
      end else if (next_free) begin
         tot = blk_size[h] + blk_size[n] + HDR;
         n2  = n + HDR + blk_size[n];
         blk_size[h] = tot;
         blk_used[h] = 1'b0;
         wipe_header(n);
         if (n2 < ARENA) blk_back[n2] = tot;
      end else begin
         blk_used[h] = 1'b0;
      end
      r.ok = 1'b1;
      foreach (live_blocks[i]) begin
         if (live_blocks[i] == a) begin
            live_blocks.delete(i);
            break;
         end
      end
      return r;
   endfunction

   // Driver: present the head of the pending queue, pop it on each accepted beat
   always @(posedge clock) begin
      arena_rsp_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (pending_reqs[0].kind == REQ_ALLOC) begin
               r = first_fit_alloc(pending_reqs[0].size);
               if (r.ok) n_alloc_ok++;
               else n_alloc_fail++;
            end else begin
               r = coalescing_free(pending_reqs[0].addr);
               if (r.ok) n_free_ok++;
               else n_free_bad++;
            end
            expected_rsps.push_back(r);
            void'(pending_reqs.pop_front());
            n_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
               req_ch.valid    <= 1'b1;
               req_ch.req_type <= pending_reqs[0].kind;
               req_ch.req_size <= pending_reqs[0].size;
               req_ch.req_addr <= pending_reqs[0].addr;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response beat with the oldest expectation
   always @(posedge clock) begin
      arena_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_checked++;
            if (expected_rsps.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("ERROR: unexpected response ok=%0b addr=%0d",
                           rsp_ch.ok, rsp_ch.block_addr);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.ok !== want.ok || rsp_ch.block_addr !== want.addr) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("ERROR: response %0d expected ok=%0b addr=%0d, got ok=%0b addr=%0d",
                              n_checked, want.ok, want.addr, rsp_ch.ok, rsp_ch.block_addr);
               end
            end
         end
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 33);
      end
   end

   task automatic push_req(input logic kind, input int unsigned size, input int unsigned addr);
      arena_req_type it;
      it.kind = kind;
      it.size = REQ_SIZE_W'(size);
      it.addr = REQ_ADDR_W'(addr);
      pending_reqs.push_back(it);
   endtask

   task automatic push_random_req();
      int unsigned pick;
      int unsigned sz;
      pick = $urandom_range(99);
      if (live_blocks.size() > 0 && pick < (live_blocks.size() > 24 ? 60 : 38)) begin
         // mostly well-formed frees, some off by a word
         sz = live_blocks[$urandom_range(live_blocks.size() - 1)];
         if ($urandom_range(9) == 0) sz = (sz + $urandom_range(2) - 1) & (ARENA - 1);
         push_req(REQ_FREE, $urandom_range(2047), sz);
      end else if (pick < 45) begin
         push_req(REQ_FREE, $urandom_range(2047), $urandom_range(ARENA - 1));
      end else begin
         pick = $urandom_range(99);
         if (pick < 75) sz = $urandom_range(40);
         else if (pick < 92) sz = $urandom_range(200);
         else sz = $urandom_range(1024);
         push_req(REQ_ALLOC, sz, $urandom_range(ARENA - 1));
      end
   endtask

   initial begin
      arena_clear();
      n_accepted = 0;
      n_checked = 0;
      n_errors = 0;
      n_alloc_ok = 0;
      n_alloc_fail = 0;
      n_free_ok = 0;
      n_free_bad = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_ALLOC;
      req_ch.req_size = '0;
      req_ch.req_addr = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: oversize, whole-arena, empty arena, bad frees, splits, merges
      push_req(REQ_ALLOC, 1024, 0);
      push_req(REQ_ALLOC, 1021, 0);
      push_req(REQ_ALLOC, 0, 1023);
      push_req(REQ_FREE, 2047, 0);
      push_req(REQ_FREE, 0, 2);
      push_req(REQ_FREE, 0, 1023);
      push_req(REQ_FREE, 0, 3);
      push_req(REQ_FREE, 0, 3);
      push_req(REQ_ALLOC, 1019, 0);
      push_req(REQ_FREE, 0, 3);
      push_req(REQ_ALLOC, 0, 0);
      push_req(REQ_ALLOC, 5, 0);
      push_req(REQ_ALLOC, 5, 0);
      push_req(REQ_ALLOC, 5, 0);
      push_req(REQ_FREE, 0, 14);
      push_req(REQ_FREE, 0, 6);
      push_req(REQ_FREE, 0, 22);
      push_req(REQ_FREE, 0, 3);
      push_req(REQ_ALLOC, 10, 0);
      push_req(REQ_ALLOC, 10, 0);
      push_req(REQ_FREE, 0, 3);
      push_req(REQ_FREE, 0, 16);
      push_req(REQ_ALLOC, 2, 0);

      for (int i = 0; i < N_RANDOM; i++) begin
         // keep the generator close to the driver so live addresses are current
         while (pending_reqs.size() > 1) @(posedge clock);
         quiet = (i >= 600 && i < 850);
         push_random_req();
      end
      quiet = 1'b0;
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Run covered %0d requests: %0d allocations served, %0d refused,",
               n_accepted, n_alloc_ok, n_alloc_fail);
      $display("%0d frees accepted, %0d rejected, %0d responses checked",
               n_free_ok, n_free_bad, n_checked);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Timeout with %0d responses outstanding", expected_rsps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
src/ffbt_pkg.sv
src/ffbt_req_if.sv
src/ffbt_rsp_if.sv
src/ffbt_ram.sv
src/ffbt_ctrl.sv
src/first_fit_boundary_tag_allocator.sv
verif/first_fit_boundary_tag_allocator_tb.sv
